[sv/pptc_pkg.sv]
// Shared types, constants and helpers for the partial permutation tree counter.
// No dependencies; imported by every module of the block.
package pptc_pkg;

    localparam int MAX_SET_SIZE = 32;
    localparam int SIZE_W       = 6;
    localparam int CNT_W        = 64;
    localparam int PROD_W       = CNT_W + SIZE_W;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 2 * CNT_W;
    localparam int OUT_TUSER_W  = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic bad;
        logic mul_en;
        logic add_en;
    } t_dp_ctl;

    typedef struct packed {
        logic last_step;
    } t_dp_sts;

    function automatic logic is_bad_request(input logic [SIZE_W-1:0] set_size,
                                            input logic [SIZE_W-1:0] pick_depth);
        logic r;
        r = (pick_depth == '0) || (pick_depth > set_size)
            || (set_size > SIZE_W'(MAX_SET_SIZE));
        return r;
    endfunction

endpackage

[sv/pptc_ctrl.sv]
// Sequencer for the partial permutation tree counter: job accept, step loop, result hold.
// Depends on pptc_pkg.
module pptc_ctrl
    import pptc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_bad,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl,
    output logic    o_in_ready,
    output logic    o_out_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_bad ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_ADD;
            ST_ADD: begin
                n_state = i_sts.last_step ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
                o_ctl.bad  = i_bad;
            end
            ST_MUL:  o_ctl.mul_en = 1'b1;
            ST_ADD:  o_ctl.add_en = 1'b1;
            ST_DONE: o_out_valid  = 1'b1;
            default: o_ctl = '0;
        endcase
    end

endmodule

[sv/pptc_dp.sv]
// Shared multiply-accumulate unit: ways *= (m - k), nodes += ways, each level a multiply step then an accumulate step.
// Depends on pptc_pkg.
module pptc_dp
    import pptc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctl           i_ctl,
    input  logic [SIZE_W-1:0] i_set_size,
    input  logic [SIZE_W-1:0] i_pick_depth,
    output t_dp_sts           o_sts,
    output logic [CNT_W-1:0]  o_node_count,
    output logic [CNT_W-1:0]  o_leaf_count,
    output logic              o_bad_request
);

    logic [SIZE_W-1:0] r_m;
    logic [SIZE_W-1:0] r_d;
    logic [SIZE_W-1:0] r_k;
    logic [CNT_W-1:0]  r_ways;
    logic [CNT_W-1:0]  r_prod;
    logic [CNT_W-1:0]  r_node;
    logic              r_bad;
    logic [SIZE_W-1:0] w_factor;
    logic [PROD_W-1:0] w_prod;

    assign w_factor = r_m - r_k;
    assign w_prod   = PROD_W'(r_ways) * PROD_W'(w_factor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_ways <= '0;
            r_node <= '0;
            r_bad  <= 1'b0;
        end else if (i_ctl.load) begin
            r_k    <= '0;
            r_ways <= i_ctl.bad ? '0 : CNT_W'(1);
            r_node <= '0;
            r_bad  <= i_ctl.bad;
        end else if (i_ctl.add_en) begin
            r_k    <= r_k + SIZE_W'(1);
            r_ways <= r_prod;
            r_node <= r_node + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_m <= i_set_size;
            r_d <= i_pick_depth;
        end
        if (i_ctl.mul_en) begin
            r_prod <= w_prod[CNT_W-1:0];
        end
    end

    assign o_sts.last_step = (r_k == r_d - SIZE_W'(1));
    assign o_node_count    = r_node;
    assign o_leaf_count    = r_ways;
    assign o_bad_request   = r_bad;

endmodule

[sv/partial_permutation_tree_counter.sv]
// Top level of the partial permutation tree counter: stream ports, sequencer, MAC datapath.
// Depends on pptc_pkg, pptc_ctrl and pptc_dp.
//
//   channel  direction  word contents (lowest bit first)
//   s_axis   in         tdata: set_size[5:0], pick_depth[11:6], zero pad to 16
//   m_axis   out        tdata: node_count[63:0], leaf_count[127:64]; tuser: bad_request
//
// A valid job runs from acceptance until its word is shown through a multiply step and
// an accumulate step per level on the shared 64x6 MAC.
// A refused job shows its word in the cycle after acceptance.
// s_axis_tready is high only while idle; the result word holds until taken.
// Reset is synchronous, active low, and returns the block to idle.
module partial_permutation_tree_counter
    import pptc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // set_size[5:0], pick_depth[11:6]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // node_count[63:0], leaf_count[127:64]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // bad_request[0]
);

    t_dp_ctl           w_ctl;
    t_dp_sts           w_sts;
    logic [SIZE_W-1:0] w_set_size;
    logic [SIZE_W-1:0] w_pick_depth;
    logic              w_bad;
    logic [CNT_W-1:0]  w_node_count;
    logic [CNT_W-1:0]  w_leaf_count;
    logic              w_bad_request;

    assign w_set_size   = s_axis_tdata[SIZE_W-1:0];
    assign w_pick_depth = s_axis_tdata[2*SIZE_W-1:SIZE_W];
    assign w_bad        = is_bad_request(w_set_size, w_pick_depth);

    pptc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_bad       (w_bad),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    pptc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_set_size    (w_set_size),
        .i_pick_depth  (w_pick_depth),
        .o_sts         (w_sts),
        .o_node_count  (w_node_count),
        .o_leaf_count  (w_leaf_count),
        .o_bad_request (w_bad_request)
    );

    assign m_axis_tdata = {w_leaf_count, w_node_count};
    assign m_axis_tuser = OUT_TUSER_W'(w_bad_request);

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("refused job with nonzero counts");

    a_bad_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && w_bad) |=> (m_axis_tvalid && m_axis_tuser[0]))
        else $error("refused job not answered next cycle");

    a_good_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !w_bad) |=> !m_axis_tuser[0])
        else $error("valid job flagged as refused");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> (s_axis_tready && !m_axis_tvalid))
        else $error("not idle after result taken");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for partial_permutation_tree_counter: directed table plus random jobs,
// each result word checked against a tabulated tally or a behavioral count of the selection tree.
// Depends on pptc_pkg and the partial_permutation_tree_counter RTL.
module tb_top;
    import pptc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_JOBS = 75;

    typedef struct packed {
        logic [CNT_W-1:0] nodes;
        logic [CNT_W-1:0] leaves;
        logic             refused;
    } t_tree_tally;

    typedef struct packed {
        logic [SIZE_W-1:0] set_size;
        logic [SIZE_W-1:0] depth;
        t_tree_tally       tally;
    } t_job_tally;

    typedef struct packed {
        logic [SIZE_W-1:0] set_size;
        logic [SIZE_W-1:0] depth;
        logic              typed;
        t_tree_tally       tally;
    } t_probe;

    localparam t_tree_tally REFUSED = '{nodes: '0, leaves: '0, refused: 1'b1};
    localparam t_tree_tally NONE    = '0;

    localparam int N_PROBES = 25;
    localparam t_probe PROBES [N_PROBES] = '{
        '{6'd0,  6'd0,  1'b1, REFUSED},
        '{6'd0,  6'd1,  1'b1, REFUSED},
        '{6'd1,  6'd0,  1'b1, REFUSED},
        '{6'd1,  6'd1,  1'b1, '{64'd1, 64'd1, 1'b0}},
        '{6'd1,  6'd2,  1'b1, REFUSED},
        '{6'd2,  6'd0,  1'b1, REFUSED},
        '{6'd2,  6'd1,  1'b1, '{64'd2, 64'd2, 1'b0}},
        '{6'd2,  6'd2,  1'b1, '{64'd4, 64'd2, 1'b0}},
        '{6'd2,  6'd3,  1'b1, REFUSED},
        '{6'd3,  6'd3,  1'b1, '{64'd15, 64'd6, 1'b0}},
        '{6'd32, 6'd1,  1'b1, '{64'd32, 64'd32, 1'b0}},
        '{6'd32, 6'd2,  1'b1, '{64'd1024, 64'd992, 1'b0}},
        '{6'd32, 6'd0,  1'b1, REFUSED},
        '{6'd32, 6'd33, 1'b1, REFUSED},
        '{6'd33, 6'd1,  1'b1, REFUSED},
        '{6'd63, 6'd1,  1'b1, REFUSED},
        '{6'd63, 6'd63, 1'b1, REFUSED},
        '{6'd42, 6'd21, 1'b1, REFUSED},
        '{6'd21, 6'd42, 1'b1, REFUSED},
        '{6'd32, 6'd32, 1'b0, NONE},
        '{6'd32, 6'd31, 1'b0, NONE},
        '{6'd20, 6'd20, 1'b0, NONE},
        '{6'd21, 6'd21, 1'b0, NONE},
        '{6'd31, 6'd16, 1'b0, NONE},
        '{6'd10, 6'd5,  1'b0, NONE}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // set_size[5:0], pick_depth[11:6]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // node_count[63:0], leaf_count[127:64]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;        // bad_request[0]

    t_job_tally pending_tallies[$];
    int         errors = 0;
    int         cycles = 0;
    bit         hold_req = 1'b0;

    partial_permutation_tree_counter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // m!/(m-d)! leaves, partial products summed for nodes, all mod 2^64
    function automatic t_tree_tally count_tree(input logic [SIZE_W-1:0] m,
                                               input logic [SIZE_W-1:0] d);
        t_tree_tally      t;
        logic [CNT_W-1:0] ways;
        t = '0;
        ways = CNT_W'(1);
        t.refused = (d == 0) || (d > m) || (int'(m) > MAX_SET_SIZE);
        if (!t.refused) begin
            for (int k = 0; k < int'(d); k++) begin
                ways = ways * CNT_W'(int'(m) - k);
                t.nodes = t.nodes + ways;
            end
            t.leaves = ways;
        end
        return t;
    endfunction

    task automatic offer_job(input logic [SIZE_W-1:0] m, input logic [SIZE_W-1:0] d,
                             input logic typed, input t_tree_tally given);
        t_job_tally j;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, d, m};
        do @(posedge i_clk); while (!s_axis_tready);
        j.set_size = m;
        j.depth    = d;
        j.tally    = typed ? given : count_tree(m, d);
        pending_tallies.push_back(j);
    endtask

    task automatic idle_input(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // receiver: runs of always-ready, coin-flip and fixed-duty stalls, plus one long hold
    initial begin
        int mode;
        int len;
        bit held;
        held = 1'b0;
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    m_axis_tready <= 1'b0;
                end
            end else begin
                mode = $urandom_range(0, 2);
                len  = $urandom_range(5, 40);
                for (int c = 0; c < len; c++) begin
                    @(posedge i_clk);
                    case (mode)
                        0: m_axis_tready <= 1'b1;
                        1: m_axis_tready <= 1'($urandom_range(0, 1));
                        default: m_axis_tready <= (c % 5) < 3;
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_job_tally  j;
        t_tree_tally got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.nodes   = m_axis_tdata[CNT_W-1:0];
            got.leaves  = m_axis_tdata[2*CNT_W-1:CNT_W];
            got.refused = m_axis_tuser[0];
            if (pending_tallies.size() == 0) begin
                $display("%0t: unexpected word nodes %h leaves %h bad %b",
                         $time, got.nodes, got.leaves, got.refused);
                errors++;
            end else begin
                j = pending_tallies.pop_front();
                if (got.nodes !== j.tally.nodes) begin
                    $display("%0t: m=%0d d=%0d node_count exp %h got %h", $time,
                             j.set_size, j.depth, j.tally.nodes, got.nodes);
                    errors++;
                end
                if (got.leaves !== j.tally.leaves) begin
                    $display("%0t: m=%0d d=%0d leaf_count exp %h got %h", $time,
                             j.set_size, j.depth, j.tally.leaves, got.leaves);
                    errors++;
                end
                if (got.refused !== j.tally.refused) begin
                    $display("%0t: m=%0d d=%0d bad_request exp %b got %b", $time,
                             j.set_size, j.depth, j.tally.refused, got.refused);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("** partial_permutation_tree_counter: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [SIZE_W-1:0] m;
        logic [SIZE_W-1:0] d;
        int burst;
        int sent;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PROBES[p]) begin
            offer_job(PROBES[p].set_size, PROBES[p].depth, PROBES[p].typed,
                      PROBES[p].tally);
            if ($urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 4));
        end

        sent = 0;
        while (sent < RANDOM_JOBS) begin
            if (sent == 20)
                hold_req = 1'b1;
            if (sent == 60) begin
                s_axis_tvalid <= 1'b0;
                while (pending_tallies.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && sent < RANDOM_JOBS; b++) begin
                if ($urandom_range(0, 4) != 0) begin
                    m = SIZE_W'($urandom_range(2, MAX_SET_SIZE));
                    d = SIZE_W'($urandom_range(1, m));
                end else begin
                    m = SIZE_W'($urandom_range(0, 63));
                    d = SIZE_W'($urandom_range(0, 63));
                end
                offer_job(m, d, 1'b0, NONE);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_input($urandom_range(1, 6));
        end

        s_axis_tvalid <= 1'b0;
        while (pending_tallies.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_SET_SIZE + 8) @(posedge i_clk);
        if (pending_tallies.size() != 0)
            errors++;
        if (errors == 0) begin
            $display("** partial_permutation_tree_counter: PASSED **");
        end else begin
            $display("** partial_permutation_tree_counter: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/pptc_pkg.sv
sv/pptc_ctrl.sv
sv/pptc_dp.sv
sv/partial_permutation_tree_counter.sv
dv/tb_top.sv
